[hdl/morse_pair_force_accumulator_unit_assert.svh]
// Assertion helpers shared by the force accumulator modules.
`ifndef MORSE_PAIR_FORCE_ACCUMULATOR_UNIT_ASSERT_SVH
`define MORSE_PAIR_FORCE_ACCUMULATOR_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define MPFA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define MPFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mpfa_pkg.sv]
package mpfa_pkg;

   localparam int NUM_CSR = 8;
   localparam int RAD_W   = 66;
   // Divisor and remainder widths cover the widest position format.
   localparam int DIV_W   = 67;
   localparam int REM_W   = 68;
   localparam int QUOT_W  = 64;

   typedef struct packed {
      logic              start;
      logic              sqrt_mode;
      logic [6:0]        steps;
      logic [REM_W-1:0]  rem_init;
      logic [RAD_W-1:0]  num_init;
      logic [DIV_W-1:0]  divisor;
   } ds_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
   } ds_sts_type;

   typedef struct packed {
      logic idle;
      logic emit;
      logic clip;
   } seq_sts_type;

   // Reciprocal of k scaled by two to the power 32, rounded down.
   function automatic logic [32:0] recip(input logic [5:0] k);
      logic [32:0] m;
      case (k)
         6'd1:  m = 33'd4294967296;
         6'd2:  m = 33'd2147483648;
         6'd3:  m = 33'd1431655765;
         6'd4:  m = 33'd1073741824;
         6'd5:  m = 33'd858993459;
         6'd6:  m = 33'd715827882;
         6'd7:  m = 33'd613566756;
         6'd8:  m = 33'd536870912;
         6'd9:  m = 33'd477218588;
         6'd10: m = 33'd429496729;
         6'd11: m = 33'd390451572;
         6'd12: m = 33'd357913941;
         6'd13: m = 33'd330382099;
         6'd14: m = 33'd306783378;
         6'd15: m = 33'd286331153;
         6'd16: m = 33'd268435456;
         6'd17: m = 33'd252645135;
         6'd18: m = 33'd238609294;
         6'd19: m = 33'd226050910;
         6'd20: m = 33'd214748364;
         6'd21: m = 33'd204522252;
         6'd22: m = 33'd195225786;
         6'd23: m = 33'd186737708;
         6'd24: m = 33'd178956970;
         6'd25: m = 33'd171798691;
         6'd26: m = 33'd165191049;
         6'd27: m = 33'd159072862;
         6'd28: m = 33'd153391689;
         6'd29: m = 33'd148102320;
         6'd30: m = 33'd143165576;
         6'd31: m = 33'd138547332;
         6'd32: m = 33'd134217728;
         default: m = 33'd0;
      endcase
      return m;
   endfunction

endpackage

[hdl/mpfa_mul.sv]
module mpfa_mul (
   input  logic        clock,
   input  logic [32:0] mul_a,
   input  logic [32:0] mul_b,
   output logic [65:0] mul_p
);

   logic [65:0] prod_ff;
   logic [65:0] prod_in;

   assign prod_in = {33'd0, mul_a} * {33'd0, mul_b};
   assign mul_p   = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[hdl/mpfa_divsqrt.sv]
`include "morse_pair_force_accumulator_unit_assert.svh"

module mpfa_divsqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  mpfa_pkg::ds_cmd_type cmd,
   output mpfa_pkg::ds_sts_type sts
);

   logic [mpfa_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [mpfa_pkg::RAD_W-1:0]  nsh_ff, nsh_in;
   logic [mpfa_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [mpfa_pkg::DIV_W-1:0]  dv_ff, dv_in;
   logic [6:0]                  cnt_ff, cnt_in;
   logic                        mode_ff, mode_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [mpfa_pkg::REM_W-1:0]  remsh;
   logic [mpfa_pkg::REM_W-1:0]  trial;
   logic                        ge;

   // Square root mode brings down two radicand bits a step and tries 4*root+1.
   always_comb begin
      if (mode_ff) begin
         remsh = {rem_ff[mpfa_pkg::REM_W-3:0], nsh_ff[mpfa_pkg::RAD_W-1:mpfa_pkg::RAD_W-2]};
         trial = mpfa_pkg::REM_W'({quot_ff, 2'b01});
      end else begin
         remsh = {rem_ff[mpfa_pkg::REM_W-2:0], nsh_ff[mpfa_pkg::RAD_W-1]};
         trial = mpfa_pkg::REM_W'(dv_ff);
      end
      ge = remsh >= trial;
   end

   always_comb begin
      rem_in  = rem_ff;
      nsh_in  = nsh_ff;
      quot_in = quot_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in  = ge ? remsh - trial : remsh;
         nsh_in  = mode_ff ? nsh_ff << 2 : nsh_ff << 1;
         quot_in = {quot_ff[mpfa_pkg::QUOT_W-2:0], ge};
         cnt_in  = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         rem_in  = cmd.rem_init;
         nsh_in  = cmd.num_init;
         quot_in = '0;
         dv_in   = cmd.divisor;
         cnt_in  = cmd.steps;
         mode_in = cmd.sqrt_mode;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      nsh_ff  <= nsh_in;
      quot_ff <= quot_in;
      dv_ff   <= dv_in;
      mode_ff <= mode_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quot = quot_ff;

   `MPFA_ASSERT_ALWAYS(a_ds_no_restart, !(cmd.start && busy_ff), "start while busy")
   `MPFA_ASSERT_NEXT(a_ds_finish, busy_ff && cnt_ff == 7'd1, done_ff && !busy_ff, "no finish")
   `MPFA_ASSERT_NEXT(a_ds_done_pulse, done_ff, !done_ff, "done longer than one cycle")

endmodule

[hdl/mpfa_seq.sv]
module mpfa_seq #(
   parameter int POS_FRAC_BITS  = 20,
   parameter int EXP_ITERATIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic signed [31:0]    self_x,
   input  logic signed [31:0]    self_y,
   input  logic signed [31:0]    partner_x,
   input  logic signed [31:0]    partner_y,
   input  logic                  pair_kind,
   input  logic                  last_pair,
   input  logic [7:0][31:0]      cfg,
   input  logic                  out_free,
   output mpfa_pkg::seq_sts_type sts,
   output logic signed [47:0]    sum_x,
   output logic signed [47:0]    sum_y
);

   localparam int FSH = 31 - POS_FRAC_BITS;
   localparam int DSH = POS_FRAC_BITS + 5;
   localparam int KW  = $clog2(EXP_ITERATIONS + 2);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SQ0  = 5'd1;
   localparam logic [4:0] ST_SQ1  = 5'd2;
   localparam logic [4:0] ST_SQ2  = 5'd3;
   localparam logic [4:0] ST_SQW  = 5'd4;
   localparam logic [4:0] ST_TM0  = 5'd5;
   localparam logic [4:0] ST_TMW  = 5'd6;
   localparam logic [4:0] ST_SE0  = 5'd7;
   localparam logic [4:0] ST_SE1  = 5'd8;
   localparam logic [4:0] ST_SE2  = 5'd9;
   localparam logic [4:0] ST_SE3  = 5'd10;
   localparam logic [4:0] ST_SE4  = 5'd11;
   localparam logic [4:0] ST_SE5  = 5'd12;
   localparam logic [4:0] ST_PW0  = 5'd13;
   localparam logic [4:0] ST_PW1  = 5'd14;
   localparam logic [4:0] ST_FM0  = 5'd15;
   localparam logic [4:0] ST_FM1  = 5'd16;
   localparam logic [4:0] ST_FMW  = 5'd17;
   localparam logic [4:0] ST_NET  = 5'd18;
   localparam logic [4:0] ST_CP0  = 5'd19;
   localparam logic [4:0] ST_CPW  = 5'd20;
   localparam logic [4:0] ST_CP1  = 5'd21;
   localparam logic [4:0] ST_CP2  = 5'd22;
   localparam logic [4:0] ST_CP3  = 5'd23;
   localparam logic [4:0] ST_FIN  = 5'd24;

   logic [4:0]          state_ff, state_in;
   logic signed [32:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic                kind_ff, kind_in, last_ff, last_in;
   logic [63:0]         sx2_ff, sx2_in;
   logic [32:0]         r_ff, r_in;
   logic                tsel_ff, tsel_in;
   logic [4:0]          n_ff, n_in;
   logic [30:0]         f_ff, f_in;
   logic                ser_ff, ser_in;
   logic [31:0]         term_ff, term_in;
   logic signed [33:0]  acc_ff, acc_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [31:0]         x_ff, x_in;
   logic [31:0]         q0_ff, q0_in;
   logic [31:0]         e_ff, e_in, e1_ff, e1_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [63:0]         att_ff, att_in, rep_ff, rep_in;
   logic [47:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic                axis_ff, axis_in;
   logic [31:0]         u_ff, u_in;
   logic [63:0]         hp_ff, hp_in;
   logic signed [47:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                clip_ff, clip_in;

   logic [32:0]                mul_a, mul_b;
   logic [65:0]                mul_p;
   mpfa_pkg::ds_cmd_type       ds_cmd;
   mpfa_pkg::ds_sts_type       ds_sts;
   logic                       emit;

   logic [32:0]                ax, ay, ad;
   logic [31:0]                depth, rng;
   logic [mpfa_pkg::DIV_W-1:0] num_w, dv_w;
   logic                       tdone;
   logic [63:0]                tval;
   logic [32:0]                rr;
   logic [31:0]                qq;
   logic [31:0]                ecl;
   logic [63:0]                fm_num;
   logic [63:0]                diff;
   logic [63:0]                psum;
   logic [48:0]                pp;
   logic signed [49:0]         c50, v50;
   logic signed [47:0]         s_old, s_new;
   logic                       ovf;

   mpfa_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   mpfa_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (ds_cmd),
      .sts   (ds_sts)
   );

   // Shared datapath terms that several states look at.
   always_comb begin
      ax     = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      ay     = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      ad     = axis_ff ? ay : ax;
      depth  = cfg[{kind_ff, tsel_ff, 1'b0}];
      rng    = cfg[{kind_ff, tsel_ff, 1'b1}];
      num_w  = mpfa_pkg::DIV_W'({r_ff, 16'd0});
      dv_w   = mpfa_pkg::DIV_W'(rng) << DSH;
      rr     = {1'b0, x_ff} - mul_p[32:0];
      qq     = q0_ff + 32'(rr >= 33'(k_ff));
      fm_num = mul_p[63:0] >> FSH;
      diff   = (att_ff > rep_ff) ? att_ff - rep_ff : rep_ff - att_ff;
      if (acc_ff[33]) begin
         ecl = 32'd0;
      end else if (acc_ff > 34'sh0_8000_0000) begin
         ecl = 32'h8000_0000;
      end else begin
         ecl = acc_ff[31:0];
      end
      psum  = hp_ff + {16'd0, mul_p[63:16]};
      pp    = psum[63:15];
      c50   = ((axis_ff ? dy_ff[32] : dx_ff[32]) != neg_ff) ? -$signed({1'b0, pp})
                                                             : $signed({1'b0, pp});
      s_old = axis_ff ? sum_y_ff : sum_x_ff;
      v50   = $signed({{2{s_old[47]}}, s_old}) + c50;
      ovf   = (v50[49:47] != 3'b000) && (v50[49:47] != 3'b111);
      if (!ovf) begin
         s_new = v50[47:0];
      end else if (v50[49]) begin
         s_new = 48'sh8000_0000_0000;
      end else begin
         s_new = 48'sh7FFF_FFFF_FFFF;
      end
   end

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      sx2_in   = sx2_ff;
      r_in     = r_ff;
      tsel_in  = tsel_ff;
      n_in     = n_ff;
      f_in     = f_ff;
      ser_in   = ser_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      x_in     = x_ff;
      q0_in    = q0_ff;
      e_in     = e_ff;
      e1_in    = e1_ff;
      cnt_in   = cnt_ff;
      att_in   = att_ff;
      rep_in   = rep_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      axis_in  = axis_ff;
      u_in     = u_ff;
      hp_in    = hp_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      clip_in  = clip_ff;
      mul_a    = '0;
      mul_b    = '0;
      ds_cmd   = '0;
      emit     = 1'b0;
      tdone    = 1'b0;
      tval     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               dx_in    = $signed({partner_x[31], partner_x}) - $signed({self_x[31], self_x});
               dy_in    = $signed({partner_y[31], partner_y}) - $signed({self_y[31], self_y});
               kind_in  = pair_kind;
               last_in  = last_pair;
               state_in = ST_SQ0;
            end
         end
         ST_SQ0: begin
            if (dx_ff == 33'sd0 && dy_ff == 33'sd0) begin
               state_in = ST_FIN;
            end else begin
               mul_a    = ax;
               mul_b    = ax;
               state_in = ST_SQ1;
            end
         end
         ST_SQ1: begin
            sx2_in   = mul_p[63:0];
            mul_a    = ay;
            mul_b    = ay;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            ds_cmd.start     = 1'b1;
            ds_cmd.sqrt_mode = 1'b1;
            ds_cmd.steps     = 7'd33;
            ds_cmd.num_init  = {2'b00, sx2_ff} + mul_p;
            state_in         = ST_SQW;
         end
         ST_SQW: begin
            if (ds_sts.done) begin
               r_in     = ds_sts.quot[32:0];
               tsel_in  = 1'b0;
               state_in = ST_TM0;
            end
         end
         ST_TM0: begin
            if (rng == 32'd0 || num_w >= dv_w) begin
               tdone = 1'b1;
            end else begin
               ds_cmd.start    = 1'b1;
               ds_cmd.steps    = 7'd36;
               ds_cmd.rem_init = mpfa_pkg::REM_W'(num_w);
               ds_cmd.divisor  = dv_w;
               state_in        = ST_TMW;
            end
         end
         ST_TMW: begin
            if (ds_sts.done) begin
               n_in     = ds_sts.quot[35:31];
               f_in     = ds_sts.quot[30:0];
               ser_in   = 1'b0;
               state_in = ST_SE0;
            end
         end
         ST_SE0: begin
            term_in  = 32'h8000_0000;
            acc_in   = 34'sh0_8000_0000;
            k_in     = KW'(1);
            state_in = ST_SE1;
         end
         ST_SE1: begin
            if (k_ff > KW'(EXP_ITERATIONS)) begin
               state_in = ST_SE5;
            end else begin
               mul_a    = {1'b0, term_ff};
               mul_b    = ser_ff ? 33'h0_8000_0000 : {2'b00, f_ff};
               state_in = ST_SE2;
            end
         end
         ST_SE2: begin
            x_in     = mul_p[62:31];
            mul_a    = {1'b0, mul_p[62:31]};
            mul_b    = mpfa_pkg::recip(6'(k_ff));
            state_in = ST_SE3;
         end
         ST_SE3: begin
            q0_in    = mul_p[63:32];
            mul_a    = {1'b0, mul_p[63:32]};
            mul_b    = 33'(k_ff);
            state_in = ST_SE4;
         end
         ST_SE4: begin
            term_in  = qq;
            acc_in   = k_ff[0] ? acc_ff - $signed({2'b00, qq}) : acc_ff + $signed({2'b00, qq});
            k_in     = k_ff + KW'(1);
            state_in = ST_SE1;
         end
         ST_SE5: begin
            if (!ser_ff) begin
               e_in     = ecl;
               ser_in   = 1'b1;
               state_in = ST_SE0;
            end else begin
               e1_in    = ecl;
               cnt_in   = n_ff;
               state_in = ST_PW0;
            end
         end
         ST_PW0: begin
            if (cnt_ff == 5'd0) begin
               state_in = ST_FM0;
            end else begin
               mul_a    = {1'b0, e_ff};
               mul_b    = {1'b0, e1_ff};
               state_in = ST_PW1;
            end
         end
         ST_PW1: begin
            e_in     = mul_p[62:31];
            cnt_in   = cnt_ff - 5'd1;
            state_in = ST_PW0;
         end
         ST_FM0: begin
            mul_a    = {1'b0, depth};
            mul_b    = {1'b0, e_ff};
            state_in = ST_FM1;
         end
         ST_FM1: begin
            ds_cmd.start    = 1'b1;
            ds_cmd.steps    = 7'd64;
            ds_cmd.num_init = {fm_num, 2'b00};
            ds_cmd.divisor  = mpfa_pkg::DIV_W'(rng);
            state_in        = ST_FMW;
         end
         ST_FMW: begin
            if (ds_sts.done) begin
               tdone = 1'b1;
               tval  = ds_sts.quot;
            end
         end
         ST_NET: begin
            neg_in = att_ff > rep_ff;
            if (diff[63:48] != 16'd0) begin
               mag_in  = 48'hFFFF_FFFF_FFFF;
               clip_in = 1'b1;
            end else begin
               mag_in = diff[47:0];
            end
            axis_in  = 1'b0;
            state_in = ST_CP0;
         end
         ST_CP0: begin
            ds_cmd.start    = 1'b1;
            ds_cmd.steps    = 7'd64;
            ds_cmd.num_init = {ad, 31'd0, 2'b00};
            ds_cmd.divisor  = mpfa_pkg::DIV_W'(r_ff);
            state_in        = ST_CPW;
         end
         ST_CPW: begin
            if (ds_sts.done) begin
               u_in     = ds_sts.quot[31:0];
               state_in = ST_CP1;
            end
         end
         ST_CP1: begin
            mul_a    = {1'b0, mag_ff[47:16]};
            mul_b    = {1'b0, u_ff};
            state_in = ST_CP2;
         end
         ST_CP2: begin
            hp_in    = mul_p[63:0];
            mul_a    = {17'd0, mag_ff[15:0]};
            mul_b    = {1'b0, u_ff};
            state_in = ST_CP3;
         end
         ST_CP3: begin
            if (axis_ff) begin
               sum_y_in = s_new;
               state_in = ST_FIN;
            end else begin
               sum_x_in = s_new;
               axis_in  = 1'b1;
               state_in = ST_CP0;
            end
            if (ovf) begin
               clip_in = 1'b1;
            end
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit     = 1'b1;
               sum_x_in = '0;
               sum_y_in = '0;
               clip_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A finished exponential term is filed under attraction or repulsion.
      if (tdone) begin
         if (tsel_ff) begin
            rep_in   = tval;
            state_in = ST_NET;
         end else begin
            att_in   = tval;
            tsel_in  = 1'b1;
            state_in = ST_TM0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         clip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         clip_ff  <= clip_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
      sx2_ff  <= sx2_in;
      r_ff    <= r_in;
      tsel_ff <= tsel_in;
      n_ff    <= n_in;
      f_ff    <= f_in;
      ser_ff  <= ser_in;
      term_ff <= term_in;
      acc_ff  <= acc_in;
      k_ff    <= k_in;
      x_ff    <= x_in;
      q0_ff   <= q0_in;
      e_ff    <= e_in;
      e1_ff   <= e1_in;
      cnt_ff  <= cnt_in;
      att_ff  <= att_in;
      rep_ff  <= rep_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      axis_ff <= axis_in;
      u_ff    <= u_in;
      hp_ff   <= hp_in;
   end

   assign sts.idle = state_ff == ST_IDLE;
   assign sts.emit = emit;
   assign sts.clip = clip_ff;
   assign sum_x    = sum_x_ff;
   assign sum_y    = sum_y_ff;

endmodule

[hdl/morse_pair_force_accumulator_unit.sv]
// Channel   Direction  Handshake            Carries
// req_      in         req_valid/req_stall  one node pair and its last flag
// rsp_      out        rsp_valid/rsp_stall  summed force and clip flag per node
// csr_      in         csr_valid/csr_ready  coefficient register writes
//
// A pair at zero distance skips the force computation; any other pair runs the full sequence, and
// an exponential term is evaluated only when its range is nonzero and its exponent stays below 32.
// The exponent power loop runs once for each whole unit of distance over range.
// Reset is synchronous and restores all coefficients to one and clears the sums.
// A new pair is taken as soon as the sequencer is idle, even while a result waits.
// A held result stalls the sequencer only at the end of a node's last pair.
`include "morse_pair_force_accumulator_unit_assert.svh"

module morse_pair_force_accumulator_unit #(
   parameter int POS_FRAC_BITS  = 20,
   parameter int EXP_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_self_x,
   input  logic signed [31:0] req_self_y,
   input  logic signed [31:0] req_partner_x,
   input  logic signed [31:0] req_partner_y,
   input  logic               req_pair_kind,
   input  logic               req_last_pair,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_force_x,
   output logic signed [47:0] rsp_force_y,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [7:0][31:0]      cfg_ff, cfg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [47:0]    fx_ff, fx_in, fy_ff, fy_in;
   logic                  sat_ff, sat_in;
   mpfa_pkg::seq_sts_type sts;
   logic signed [47:0]    sum_x, sum_y;
   logic                  take;
   logic                  out_free;

   assign req_stall = !sts.idle;
   assign csr_ready = sts.idle;
   assign take      = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   mpfa_seq #(
      .POS_FRAC_BITS  (POS_FRAC_BITS),
      .EXP_ITERATIONS (EXP_ITERATIONS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .self_x    (req_self_x),
      .self_y    (req_self_y),
      .partner_x (req_partner_x),
      .partner_y (req_partner_y),
      .pair_kind (req_pair_kind),
      .last_pair (req_last_pair),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .sts       (sts),
      .sum_x     (sum_x),
      .sum_y     (sum_y)
   );

   always_comb begin
      cfg_in       = cfg_ff;
      rsp_valid_in = rsp_valid_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      sat_in       = sat_ff;
      if (csr_valid && csr_ready && csr_index < 4'(mpfa_pkg::NUM_CSR)) begin
         cfg_in[csr_index[2:0]] = csr_wdata;
      end
      if (sts.emit) begin
         rsp_valid_in = 1'b1;
         fx_in        = sum_x;
         fy_in        = sum_y;
         sat_in       = sts.clip;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= {mpfa_pkg::NUM_CSR{32'd65536}};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fx_ff  <= fx_in;
      fy_ff  <= fy_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_force_x   = fx_ff;
   assign rsp_force_y   = fy_ff;
   assign rsp_saturated = sat_ff;

   `MPFA_ASSERT_ALWAYS(a_emit_slot, !(sts.emit && rsp_valid_ff && rsp_stall), "result overwritten")
   `MPFA_ASSERT_NEXT(a_emit_loads, sts.emit, rsp_valid_ff, "result not presented")
   `MPFA_ASSERT_NEXT(a_take_busy, req_valid && !req_stall, !sts.idle, "pair taken but not started")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int FRAC_BITS  = 20;
   localparam int SERIES_LEN = 16;
   localparam int LIMIT      = 4000000;
   localparam int RANDOM_PER_PHASE = 100;

   localparam bit KIND_II = 1'b0;
   localparam bit KIND_MI = 1'b1;

   localparam logic [3:0] REG_ATT_DEPTH_II = 4'd0;
   localparam logic [3:0] REG_ATT_RANGE_II = 4'd1;
   localparam logic [3:0] REG_REP_DEPTH_II = 4'd2;
   localparam logic [3:0] REG_REP_RANGE_II = 4'd3;
   localparam logic [3:0] REG_ATT_DEPTH_MI = 4'd4;
   localparam logic [3:0] REG_ATT_RANGE_MI = 4'd5;
   localparam logic [3:0] REG_REP_DEPTH_MI = 4'd6;
   localparam logic [3:0] REG_REP_RANGE_MI = 4'd7;

   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -64'sh8000_0000_0000;
   localparam bit [63:0] NET_CAP = 64'hFFFF_FFFF_FFFF;
   localparam bit [63:0] ONE_Q31 = 64'h8000_0000;

   typedef struct {
      logic signed [31:0] self_x;
      logic signed [31:0] self_y;
      logic signed [31:0] partner_x;
      logic signed [31:0] partner_y;
      logic               pair_kind;
      logic               last_pair;
   } pair_type;

   typedef struct {
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic               saturated;
   } force_type;

   typedef struct {
      pair_type  pair;
      bit        typed;
      force_type want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_self_x = '0;
   logic signed [31:0] req_self_y = '0;
   logic signed [31:0] req_partner_x = '0;
   logic signed [31:0] req_partner_y = '0;
   logic               req_pair_kind = 1'b0;
   logic               req_last_pair = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [47:0] rsp_force_x;
   logic signed [47:0] rsp_force_y;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   bit [31:0] coef [8];
   longint    acc_x;
   longint    acc_y;
   bit        acc_clip;

   force_type pending_forces [$];
   int        mismatches = 0;
   int        cycles = 0;
   int        idle_pct = 0;
   int        stall_pct = 0;

   morse_pair_force_accumulator_unit DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_forces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected force result %0d %0d %0d",
                        rsp_force_x, rsp_force_y, rsp_saturated);
         end else begin
            want = pending_forces.pop_front();
            if (rsp_force_x !== want.force_x || rsp_force_y !== want.force_y ||
                rsp_saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("force mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           want.force_x, want.force_y, want.saturated,
                           rsp_force_x, rsp_force_y, rsp_saturated);
            end
         end
      end
   end

   function automatic bit [63:0] int_sqrt(bit [65:0] v);
      bit [63:0] root;
      bit [67:0] rem;
      bit [67:0] trial;
      root = 0;
      rem = 0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | v[2*i +: 2];
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic bit [63:0] exp_series(bit [63:0] f);
      longint    sum;
      bit [63:0] term;
      sum = ONE_Q31;
      term = ONE_Q31;
      for (int k = 1; k <= SERIES_LEN; k++) begin
         term = ((term * f) >> 31) / k;
         if (k & 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q31)) sum = ONE_Q31;
      return sum;
   endfunction

   function automatic bit [63:0] morse_term(bit [63:0] r, bit [31:0] depth, bit [31:0] range);
      bit [63:0] num, den, n, rem, f, e, e1;
      if (range == 0) return 0;
      num = r << 16;
      den = 64'(range) << FRAC_BITS;
      n = num / den;
      if (n >= 32) return 0;
      rem = num - n * den;
      f = 0;
      for (int i = 0; i < 31; i++) begin
         rem = rem << 1;
         f = f << 1;
         if (rem >= den) begin
            rem = rem - den;
            f = f | 1;
         end
      end
      e = exp_series(f);
      e1 = exp_series(ONE_Q31);
      while (n > 0) begin
         e = (e * e1) >> 31;
         n--;
      end
      return ((64'(depth) * e) >> (31 - FRAC_BITS)) / range;
   endfunction

   function automatic longint axis_share(longint d, bit [63:0] r, bit [63:0] mag, bit net_neg);
      bit [63:0] ad, u, p;
      ad = (d < 0) ? -d : d;
      u = (ad << 31) / r;
      p = (((mag >> 16) * u) + (((mag & 64'hFFFF) * u) >> 16)) >> 15;
      return ((d < 0) != net_neg) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint clip_add(longint s, longint c);
      longint v;
      v = s + c;
      if (v > SUM_HI) begin
         v = SUM_HI;
         acc_clip = 1;
      end
      if (v < SUM_LO) begin
         v = SUM_LO;
         acc_clip = 1;
      end
      return v;
   endfunction

   function automatic bit accumulate_pair(pair_type p, output force_type res);
      longint    dx, dy;
      bit [63:0] ax, ay, r, att, rep, mag;
      bit [65:0] rsq;
      int        base;
      bit        neg;
      dx = longint'(p.partner_x) - longint'(p.self_x);
      dy = longint'(p.partner_y) - longint'(p.self_y);
      res = '{default: '0};
      if (dx != 0 || dy != 0) begin
         base = (p.pair_kind == KIND_MI) ? 4 : 0;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         rsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
         r = int_sqrt(rsq);
         att = morse_term(r, coef[base], coef[base+1]);
         rep = morse_term(r, coef[base+2], coef[base+3]);
         neg = att > rep;
         mag = neg ? att - rep : rep - att;
         if (mag > NET_CAP) begin
            mag = NET_CAP;
            acc_clip = 1;
         end
         acc_x = clip_add(acc_x, axis_share(dx, r, mag, neg));
         acc_y = clip_add(acc_y, axis_share(dy, r, mag, neg));
      end
      if (p.last_pair) begin
         res.force_x = acc_x[47:0];
         res.force_y = acc_y[47:0];
         res.saturated = acc_clip;
         acc_x = 0;
         acc_y = 0;
         acc_clip = 0;
         return 1;
      end
      return 0;
   endfunction

   task automatic write_coef(logic [3:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      coef[idx[2:0]] = val;
   endtask

   task automatic load_coefs(bit [31:0] vals [8]);
      for (int i = 0; i < 8; i++) write_coef(4'(i), vals[i]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pair(pair_type p, bit typed, force_type want);
      force_type got;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_self_x    <= p.self_x;
      req_self_y    <= p.self_y;
      req_partner_x <= p.partner_x;
      req_partner_y <= p.partner_y;
      req_pair_kind <= p.pair_kind;
      req_last_pair <= p.last_pair;
      do @(posedge clock); while (req_stall);
      if (accumulate_pair(p, got)) pending_forces.push_back(typed ? want : got);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   function automatic pair_type random_pair(bit last);
      pair_type p;
      p.self_x = $urandom;
      p.self_y = $urandom;
      p.pair_kind = 1'($urandom_range(0, 1));
      p.last_pair = last;
      case ($urandom_range(0, 9))
         0, 1: begin
            p.partner_x = $urandom;
            p.partner_y = $urandom;
         end
         2: begin
            p.partner_x = p.self_x + $signed($urandom_range(0, 8)) - 4;
            p.partner_y = p.self_y + $signed($urandom_range(0, 8)) - 4;
         end
         default: begin
            p.partner_x = p.self_x + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            p.partner_y = p.self_y + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
         end
      endcase
      return p;
   endfunction

   task automatic random_traffic(int count);
      int        sent, len;
      force_type none;
      none = '{default: '0};
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_pair(random_pair(1'($urandom_range(0, 1))), 0, none);
            sent++;
         end else begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) send_pair(random_pair(i == len - 1), 0, none);
            sent += len;
         end
      end
      send_pair(random_pair(1), 0, none);
   endtask

   initial begin
      row_type   rows [$];
      bit [31:0] vals [8];
      force_type zero_force;
      zero_force = '{default: '0};
      for (int i = 0; i < 8; i++) coef[i] = 32'h0001_0000;
      acc_x = 0;
      acc_y = 0;
      acc_clip = 0;

      rows.push_back('{'{32'sd5, -32'sd7, 32'sd5, -32'sd7, KIND_II, 1'b1}, 1, zero_force});
      rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         KIND_II, 1'b1}, 1, zero_force});
      rows.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         KIND_MI, 1'b1}, 1, zero_force});
      rows.push_back('{'{32'sd0, 32'sd0, 32'sh0010_0000, 32'sd0, KIND_II, 1'b0}, 0, zero_force});
      rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, -32'sh0018_0000, KIND_MI, 1'b1}, 0, zero_force});
      rows.push_back('{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, KIND_II, 1'b1}, 0, zero_force});
      rows.push_back('{'{32'sh0030_0000, 32'sd0, 32'sd0, 32'sh0020_0000, KIND_II, 1'b0}, 0,
                      zero_force});
      rows.push_back('{'{32'sd9, 32'sd9, 32'sd9, 32'sd9, KIND_MI, 1'b0}, 0, zero_force});
      rows.push_back('{'{-32'sh0008_0000, 32'sh0004_0000, 32'sd0, 32'sd0, KIND_MI, 1'b1}, 0,
                      zero_force});
      rows.push_back('{'{32'sd0, 32'sd0, 32'sh0280_0000, 32'sd0, KIND_II, 1'b1}, 0, zero_force});
      rows.push_back('{'{32'sd0, 32'sd0, 32'sh2800_0000, 32'sd0, KIND_MI, 1'b1}, 0, zero_force});
      rows.push_back('{'{32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFF0, 32'sd3, KIND_II, 1'b1}, 0,
                      zero_force});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < rows.size(); i++) send_pair(rows[i].pair, rows[i].typed, rows[i].want);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               for (int i = 0; i < 8; i++) vals[i] = 32'h0001_0000;
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               for (int i = 0; i < 8; i += 2) begin
                  vals[i] = $urandom_range(0, 32'h0010_0000);
                  vals[i+1] = $urandom_range(32'h0000_4000, 32'h0004_0000);
               end
               idle_pct = 48;
               stall_pct = 0;
            end
            2: begin
               vals[REG_ATT_DEPTH_II] = 32'hFFFF_FFFF;
               vals[REG_ATT_RANGE_II] = 32'd1;
               vals[REG_REP_DEPTH_II] = 32'hFFFF_FFFF;
               vals[REG_REP_RANGE_II] = 32'hFFFF_FFFF;
               vals[REG_ATT_DEPTH_MI] = 32'd0;
               vals[REG_ATT_RANGE_MI] = 32'hFFFF_FFFF;
               vals[REG_REP_DEPTH_MI] = 32'hFFFF_FFFF;
               vals[REG_REP_RANGE_MI] = 32'd1;
               idle_pct = 0;
               stall_pct = 48;
            end
            default: begin
               for (int i = 0; i < 8; i++) begin
                  vals[i] = $urandom;
                  if (i % 2 == 1 && vals[i] == 0) vals[i] = 1;
               end
               idle_pct = 15;
               stall_pct = 15;
            end
         endcase
         load_coefs(vals);
         random_traffic(RANDOM_PER_PHASE);
         drain();
      end

      if (mismatches == 0 && pending_forces.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[morse_pair_force_accumulator_unit.f]
+incdir+hdl
hdl/mpfa_pkg.sv
hdl/mpfa_mul.sv
hdl/mpfa_divsqrt.sv
hdl/mpfa_seq.sv
hdl/morse_pair_force_accumulator_unit.sv
bench/tb.sv
